### design/jss_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// jss_pkg
// Shared types, codes and sizes of the job slot scheduler.
// ----------------------------------------------------------------------------
package jss_pkg;

  localparam int unsigned NumSlots = 64;
  localparam int unsigned SlotW    = $clog2(NumSlots);
  localparam int unsigned CntW     = SlotW + 1;
  localparam int unsigned GenW     = 16;
  localparam int unsigned StepW    = 5;

  // item modes
  localparam logic [2:0] MODE_SUBMIT   = 3'd0;
  localparam logic [2:0] MODE_DISPATCH = 3'd1;
  localparam logic [2:0] MODE_COMPLETE = 3'd2;
  localparam logic [2:0] MODE_QUERY    = 3'd3;
  localparam logic [2:0] MODE_RELEASE  = 3'd4;

  // submit result codes
  localparam logic [1:0] CODE_OK       = 2'd0;
  localparam logic [1:0] CODE_INVALID  = 2'd1;
  localparam logic [1:0] CODE_OVERFLOW = 2'd2;

  // slot phases
  localparam logic [2:0] PH_FREE   = 3'd0;
  localparam logic [2:0] PH_WAIT   = 3'd1;
  localparam logic [2:0] PH_QUEUED = 3'd2;
  localparam logic [2:0] PH_RUN    = 3'd3;
  localparam logic [2:0] PH_FIN    = 3'd4;

  // job status
  localparam logic [1:0] JS_PENDING = 2'd0;
  localparam logic [1:0] JS_RUNNING = 2'd1;
  localparam logic [1:0] JS_DONE    = 2'd2;
  localparam logic [1:0] JS_FAILED  = 2'd3;

  // controller steps
  localparam logic [StepW-1:0] S_IDLE     = 5'd0;
  localparam logic [StepW-1:0] S_NOP      = 5'd1;
  localparam logic [StepW-1:0] S_SUB_A    = 5'd2;
  localparam logic [StepW-1:0] S_SUB_CHK  = 5'd3;
  localparam logic [StepW-1:0] S_SUB_WR   = 5'd4;
  localparam logic [StepW-1:0] S_SUB_LINK = 5'd5;
  localparam logic [StepW-1:0] S_DIS_RING = 5'd6;
  localparam logic [StepW-1:0] S_DIS_REC  = 5'd7;
  localparam logic [StepW-1:0] S_DIS_WR   = 5'd8;
  localparam logic [StepW-1:0] S_CMP_RD   = 5'd9;
  localparam logic [StepW-1:0] S_CMP_CHK  = 5'd10;
  localparam logic [StepW-1:0] S_FIN_WR   = 5'd11;
  localparam logic [StepW-1:0] S_FIN_RD   = 5'd12;
  localparam logic [StepW-1:0] S_FIN_DEP  = 5'd13;
  localparam logic [StepW-1:0] S_QRY_RD   = 5'd14;
  localparam logic [StepW-1:0] S_QRY_OUT  = 5'd15;
  localparam logic [StepW-1:0] S_REL_RD   = 5'd16;
  localparam logic [StepW-1:0] S_REL_WR   = 5'd17;

  typedef struct packed {
    logic [2:0]      phase;
    logic [1:0]      status;
    logic [CntW-1:0] dep;
    logic            det;
    logic [GenW-1:0] gen;
  } slot_rec_t;

  typedef struct packed {
    logic [2:0]  mode;
    logic [63:0] job_word;
    logic [31:0] after_handle;
    logic [31:0] handle;
    logic [5:0]  slot;
    logic        failed;
  } jss_in_t;

  typedef struct packed {
    logic [1:0]  code;
    logic [31:0] result_handle;
    logic        got_job;
    logic [5:0]  job_slot;
    logic [63:0] job_out;
    logic        handle_valid;
    logic [1:0]  job_status;
  } jss_out_t;

  typedef struct packed {
    logic             latch;
    logic [StepW-1:0] step;
    logic             emit;
  } jss_cmd_t;

  typedef struct packed {
    logic sub_bad;
    logic link_need;
    logic ring_empty;
    logic slot_oob;
    logic not_running;
    logic fin_more;
    logic fin_chain;
  } jss_stat_t;

endpackage
`default_nettype wire

### design/jss_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// jss_ctrl
// Sequencer of the scheduler: walks each item through its datapath steps.
// ----------------------------------------------------------------------------
module jss_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [2:0]        mode_i,
  input  wire jss_pkg::jss_stat_t stat_i,
  output jss_pkg::jss_cmd_t      cmd_o,
  output logic                   busy_o
);
  import jss_pkg::*;

  logic [StepW-1:0] state_q, state_d;
  logic             emit;

  always_comb begin
    state_d = state_q;
    emit    = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          unique case (mode_i)
            MODE_SUBMIT:   state_d = S_SUB_A;
            MODE_DISPATCH: state_d = S_DIS_RING;
            MODE_COMPLETE: state_d = S_CMP_RD;
            MODE_QUERY:    state_d = S_QRY_RD;
            MODE_RELEASE:  state_d = S_REL_RD;
            default:       state_d = S_NOP;
          endcase
        end
      end
      S_NOP: begin
        emit = 1'b1; state_d = S_IDLE;
      end
      S_SUB_A:   state_d = S_SUB_CHK;
      S_SUB_CHK: begin
        if (stat_i.sub_bad) begin
          emit = 1'b1; state_d = S_IDLE;
        end else begin
          state_d = S_SUB_WR;
        end
      end
      S_SUB_WR: begin
        if (stat_i.link_need) begin
          state_d = S_SUB_LINK;
        end else begin
          emit = 1'b1; state_d = S_IDLE;
        end
      end
      S_SUB_LINK: begin
        emit = 1'b1; state_d = S_IDLE;
      end
      S_DIS_RING: begin
        if (stat_i.ring_empty) begin
          emit = 1'b1; state_d = S_IDLE;
        end else begin
          state_d = S_DIS_REC;
        end
      end
      S_DIS_REC: state_d = S_DIS_WR;
      S_DIS_WR: begin
        emit = 1'b1; state_d = S_IDLE;
      end
      S_CMP_RD: begin
        if (stat_i.slot_oob) begin
          emit = 1'b1; state_d = S_IDLE;
        end else begin
          state_d = S_CMP_CHK;
        end
      end
      S_CMP_CHK: begin
        if (stat_i.not_running) begin
          emit = 1'b1; state_d = S_IDLE;
        end else begin
          state_d = S_FIN_WR;
        end
      end
      S_FIN_WR: begin
        if (stat_i.fin_more) begin
          state_d = S_FIN_RD;
        end else begin
          emit = 1'b1; state_d = S_IDLE;
        end
      end
      S_FIN_RD:  state_d = stat_i.fin_chain ? S_FIN_WR : S_FIN_DEP;
      S_FIN_DEP: begin
        emit = 1'b1; state_d = S_IDLE;
      end
      S_QRY_RD:  state_d = S_QRY_OUT;
      S_QRY_OUT: begin
        emit = 1'b1; state_d = S_IDLE;
      end
      S_REL_RD:  state_d = S_REL_WR;
      S_REL_WR: begin
        emit = 1'b1; state_d = S_IDLE;
      end
      default:   state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o      = (state_q != S_IDLE);
  assign cmd_o.latch = start_i && (state_q == S_IDLE);
  assign cmd_o.step  = state_q;
  assign cmd_o.emit  = emit;

endmodule
`default_nettype wire

### design/jss_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// jss_datapath
// Slot record memory, job word memory, ready ring and result register.
// ----------------------------------------------------------------------------
module jss_datapath (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire jss_pkg::jss_cmd_t  cmd_i,
  output jss_pkg::jss_stat_t      stat_o,
  input  wire jss_pkg::jss_in_t   in_i,
  output jss_pkg::jss_out_t       out_o,
  output logic                    done_o,
  input  wire logic               cfg_we_i,
  input  wire logic [6:0]         cfg_data_i
);
  import jss_pkg::*;

  slot_rec_t   rec_mem  [NumSlots];
  logic [63:0] job_mem  [NumSlots];
  logic [SlotW-1:0] ring_mem [NumSlots];

  logic [NumSlots-1:0] vld_q, free_q;
  logic [6:0]          active_q;
  logic [SlotW-1:0]    head_q, tail_q;
  logic [CntW-1:0]     count_q;
  logic                done_q;

  jss_in_t          in_q;
  jss_out_t         res_q;
  slot_rec_t        rd_q, arec_q;
  logic             rdv_q;
  logic [SlotW-1:0] ring_q, fidx_q, aidx_q, cur_q;
  logic [63:0]      job_q;
  logic             found_q, av_q, chain_q;
  logic [CntW-1:0]  steps_q;
  logic [1:0]       fst_q;

  logic [CntW-1:0]     n;
  logic [NumSlots-1:0] slot_mask, free_m;
  logic [SlotW-1:0]    fidx;
  slot_rec_t           rec_eff, wdata;
  logic                rec_we, rd_en, ring_rd, push, job_we, job_rd;
  logic [SlotW-1:0]    waddr, rd_addr, push_val, job_addr;
  logic [31:0]         a_p, h_p;
  logic                a_res, h_res, conflict;
  logic                a_fin, a_failed;
  logic [CntW-1:0]     d_m1;
  logic                d_ok, self_ok;
  logic                can_push;

  // slot count clamped to 1..NumSlots
  always_comb begin
    if (active_q == '0) begin
      n = CntW'(1);
    end else if (active_q > 7'(NumSlots)) begin
      n = CntW'(NumSlots);
    end else begin
      n = CntW'(active_q);
    end
  end

  function automatic logic [SlotW-1:0] adv(input logic [SlotW-1:0] p,
                                            input logic [CntW-1:0] cnt);
    logic [CntW-1:0] nx;
    nx = {1'b0, p} + CntW'(1);
    return (nx >= cnt) ? '0 : nx[SlotW-1:0];
  endfunction

  // lowest free slot below the slot count
  always_comb begin
    fidx = '0;
    for (int k = 0; k < NumSlots; k++) begin
      slot_mask[k] = (CntW'(k) < n);
    end
    free_m = free_q & slot_mask;
    for (int k = NumSlots - 1; k >= 0; k--) begin
      if (free_m[k]) fidx = SlotW'(k);
    end
  end

  // never written records read as the reset record, which is all zero
  assign rec_eff = rdv_q ? rd_q : '0;

  assign a_p   = in_q.after_handle - 32'd1;
  assign h_p   = in_q.handle - 32'd1;
  assign a_res = (in_q.after_handle != '0) && (a_p[15:0] < {{(16-CntW){1'b0}}, n}) &&
                 (rec_eff.gen == a_p[31:16]) && !rec_eff.det;
  assign h_res = (in_q.handle != '0) && (h_p[15:0] < {{(16-CntW){1'b0}}, n}) &&
                 (rec_eff.gen == h_p[31:16]) && !rec_eff.det;
  assign conflict = a_res && (rec_eff.phase != PH_FIN) && (rec_eff.dep != '0);

  assign a_fin    = av_q && (arec_q.phase == PH_FIN);
  assign a_failed = a_fin && (arec_q.status == JS_FAILED);

  assign d_m1    = rec_eff.dep - CntW'(1);
  assign d_ok    = (rec_eff.dep != '0) && (d_m1 < n);
  assign self_ok = d_ok && (fst_q != JS_FAILED) && (d_m1[SlotW-1:0] == cur_q);

  assign can_push = (count_q < n);

  always_comb begin
    rec_we   = 1'b0;
    waddr    = '0;
    wdata    = '0;
    rd_en    = 1'b0;
    rd_addr  = '0;
    ring_rd  = 1'b0;
    push     = 1'b0;
    push_val = '0;
    job_we   = 1'b0;
    job_rd   = 1'b0;
    job_addr = '0;
    stat_o   = '0;
    stat_o.sub_bad     = conflict || !found_q;
    stat_o.ring_empty  = (count_q == '0);
    stat_o.slot_oob    = ({1'b0, in_q.slot} >= n);
    stat_o.not_running = (rec_eff.phase != PH_RUN);
    stat_o.fin_chain   = chain_q;
    unique case (cmd_i.step)
      S_SUB_A: begin
        rd_en = 1'b1; rd_addr = a_p[SlotW-1:0];
      end
      S_SUB_CHK: begin
        rd_en    = 1'b1;
        rd_addr  = fidx_q;
        job_we   = !(conflict || !found_q);
        job_addr = fidx_q;
      end
      S_SUB_WR: begin
        rec_we = 1'b1;
        waddr  = fidx_q;
        wdata.gen = rec_eff.gen;
        if (a_failed) begin
          wdata.phase  = PH_FIN;
          wdata.status = JS_FAILED;
        end else if (!av_q || a_fin) begin
          wdata.phase  = PH_QUEUED;
          wdata.status = JS_PENDING;
          push     = 1'b1;
          push_val = fidx_q;
        end else if (aidx_q == fidx_q) begin
          // waits on its own freed slot: self link
          wdata.phase  = PH_WAIT;
          wdata.status = JS_PENDING;
          wdata.dep    = {1'b0, fidx_q} + CntW'(1);
        end else begin
          wdata.phase  = PH_WAIT;
          wdata.status = JS_PENDING;
          stat_o.link_need = 1'b1;
        end
      end
      S_SUB_LINK: begin
        rec_we    = 1'b1;
        waddr     = aidx_q;
        wdata     = arec_q;
        wdata.dep = {1'b0, fidx_q} + CntW'(1);
      end
      S_DIS_RING: begin
        ring_rd = (count_q != '0);
      end
      S_DIS_REC: begin
        rd_en = 1'b1; rd_addr = ring_q;
        job_rd = 1'b1; job_addr = ring_q;
      end
      S_DIS_WR: begin
        rec_we = 1'b1;
        waddr  = cur_q;
        wdata  = rec_eff;
        wdata.phase  = PH_RUN;
        wdata.status = JS_RUNNING;
      end
      S_CMP_RD: begin
        rd_en = !stat_o.slot_oob; rd_addr = in_q.slot[SlotW-1:0];
      end
      S_FIN_WR: begin
        rec_we = 1'b1;
        waddr  = cur_q;
        if (self_ok) begin
          // success readies itself, then a detached slot is freed at once
          wdata.phase  = rec_eff.det ? PH_FREE : PH_QUEUED;
          wdata.status = JS_PENDING;
          wdata.gen    = rec_eff.gen + GenW'(rec_eff.det);
          push     = 1'b1;
          push_val = cur_q;
        end else begin
          wdata.phase  = rec_eff.det ? PH_FREE : PH_FIN;
          wdata.status = fst_q;
          wdata.gen    = rec_eff.gen + GenW'(rec_eff.det);
          stat_o.fin_more = d_ok && ((fst_q != JS_FAILED) || (steps_q < n));
        end
      end
      S_FIN_RD: begin
        rd_en = 1'b1; rd_addr = cur_q;
      end
      S_FIN_DEP: begin
        rec_we = 1'b1;
        waddr  = cur_q;
        wdata  = rec_eff;
        wdata.phase  = PH_QUEUED;
        wdata.status = JS_PENDING;
        push     = 1'b1;
        push_val = cur_q;
      end
      S_QRY_RD, S_REL_RD: begin
        rd_en = 1'b1; rd_addr = h_p[SlotW-1:0];
      end
      S_REL_WR: begin
        rec_we = h_res;
        waddr  = h_p[SlotW-1:0];
        wdata  = rec_eff;
        if (rec_eff.phase == PH_FIN) begin
          wdata.phase = PH_FREE;
          wdata.det   = 1'b0;
          wdata.gen   = rec_eff.gen + GenW'(1);
        end else begin
          wdata.det = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 7'(NumSlots);
      vld_q    <= '0;
      free_q   <= '1;
      head_q   <= '0;
      tail_q   <= '0;
      count_q  <= '0;
    end else if (cfg_we_i) begin
      active_q <= cfg_data_i;
      vld_q    <= '0;
      free_q   <= '1;
      head_q   <= '0;
      tail_q   <= '0;
      count_q  <= '0;
    end else begin
      if (rec_we) begin
        vld_q[waddr]  <= 1'b1;
        free_q[waddr] <= (wdata.phase == PH_FREE);
      end
      if (push && can_push) begin
        tail_q  <= adv(tail_q, n);
        count_q <= count_q + CntW'(1);
      end
      if (cmd_i.step == S_DIS_REC) begin
        head_q  <= adv(head_q, n);
        count_q <= count_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= cmd_i.emit;
    end
  end

  // memories and payload
  always_ff @(posedge clk_i) begin
    if (rec_we) rec_mem[waddr] <= wdata;
    if (rd_en) begin
      rd_q  <= rec_mem[rd_addr];
      rdv_q <= vld_q[rd_addr];
    end
    if (job_we) job_mem[job_addr] <= in_q.job_word;
    if (job_rd) job_q <= job_mem[job_addr];
    if (push && can_push) ring_mem[tail_q] <= push_val;
    if (ring_rd) ring_q <= ring_mem[head_q];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      in_q  <= in_i;
      res_q <= '0;
    end
    unique case (cmd_i.step)
      S_SUB_A: begin
        fidx_q  <= fidx;
        found_q <= |free_m;
      end
      S_SUB_CHK: begin
        av_q   <= a_res;
        arec_q <= rec_eff;
        aidx_q <= a_p[SlotW-1:0];
        if (conflict) begin
          res_q.code <= CODE_INVALID;
        end else if (!found_q) begin
          res_q.code <= CODE_OVERFLOW;
        end
      end
      S_SUB_WR: begin
        res_q.result_handle <= {rec_eff.gen, {(16-SlotW){1'b0}}, fidx_q} + 32'd1;
      end
      S_DIS_REC: cur_q <= ring_q;
      S_DIS_WR: begin
        res_q.got_job  <= 1'b1;
        res_q.job_slot <= 6'(cur_q);
        res_q.job_out  <= job_q;
      end
      S_CMP_RD: begin
        cur_q   <= in_q.slot[SlotW-1:0];
        steps_q <= '0;
        fst_q   <= in_q.failed ? JS_FAILED : JS_DONE;
      end
      S_FIN_WR: begin
        if (stat_o.fin_more) begin
          cur_q   <= d_m1[SlotW-1:0];
          chain_q <= (fst_q == JS_FAILED);
          steps_q <= steps_q + CntW'(1);
        end
      end
      S_QRY_OUT: begin
        res_q.handle_valid <= h_res;
        res_q.job_status   <= h_res ? rec_eff.status : JS_FAILED;
      end
      default: begin
      end
    endcase
  end

  assign out_o  = res_q;
  assign done_o = done_q;

endmodule
`default_nettype wire

### design/job_slot_scheduler_with_dependencies_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// job_slot_scheduler_with_dependencies_core
// Job pool with generational handles, single dependent links and a ready ring.
// ----------------------------------------------------------------------------
// An item is taken when start_i is high and busy_o is low; its one result
// shows on out_o for a single cycle with done_o high, and the receiver cannot
// stall it. Each item runs through a sequencer stepping over single-port slot
// records: an unknown mode, a dispatch with no ready job and a complete whose
// slot is out of range end after their first step; query, release, rejected
// submits and a complete of a slot that is not running after their second.
// An accepted submit writes its record, then a link to the awaited job if
// that job is unfinished in another slot; a dispatch that finds a job reads
// the ring, the record, and writes it; a complete writes the finished record,
// then may ready a dependent or walk a failed chain; each record read is
// registered. A new item may start in the cycle of the result. Writing
// active_slots over the cfg channel (only while idle) clears the whole pool.
module job_slot_scheduler_with_dependencies_core (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  output logic                   busy_o,
  input  wire jss_pkg::jss_in_t  in_i,
  output logic                   done_o,
  output jss_pkg::jss_out_t      out_o,
  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire logic [6:0]        cfg_data_i
);
  import jss_pkg::*;

  jss_cmd_t  cmd;
  jss_stat_t stat;

  assign cfg_ready_o = !busy_o;

  jss_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .mode_i (in_i.mode),
    .stat_i (stat),
    .cmd_o  (cmd),
    .busy_o (busy_o)
  );

  jss_datapath u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .stat_o    (stat),
    .in_i      (in_i),
    .out_o     (out_o),
    .done_o    (done_o),
    .cfg_we_i  (cfg_valid_i && cfg_ready_o),
    .cfg_data_i(cfg_data_i)
  );

`ifndef ASSERT_OFF
  // a result only appears once the sequencer is back at rest
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o) else $error("result while busy");

  // an accepted item always occupies the sequencer
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o) else $error("item accepted without work");

  // no two results back to back
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result repeated");
`endif

endmodule
`default_nettype wire
